>>> hdl/sdai_pkg.sv
// shared types and constants for the signed integer to decimal text unit
// no dependencies

package sdai_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CharWidth  = 6;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned BcdWidth   = NumDigits * DigitWidth;
  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned NumSteps   = ValueWidth / BitsPerStep;
  localparam int unsigned StepCntWidth = $clog2(NumSteps);
  localparam int unsigned PtrWidth   = $clog2(NumDigits);

  localparam logic [CharWidth-1:0] CharZero  = 6'd48;
  localparam logic [CharWidth-1:0] CharMinus = 6'd45;

  typedef struct packed {
    logic load;        // capture value, form magnitude, clear bcd
    logic shift;       // one double-dabble step of several bits
    logic prep;        // locate leading digit, emit sign if negative
    logic emit_digit;  // emit digit at pointer, step pointer down
  } dp_cmd_t;

  typedef struct packed {
    logic ptr_zero;    // pointer sits at the least significant digit
  } dp_status_t;

endpackage

>>> hdl/signed_int_to_decimal_ascii_unit.sv
// signed 32-bit integer to decimal ascii text, one character per valid_o strobe
// the minus sign, if negative, comes first, then the digits most significant first, one per cycle
// busy from acceptance until the last of n = 1..10 digits is issued; a new value is taken only
// when idle; conversion is eight 4-bit double-dabble steps, then a prep step locates the
// leading digit; the receiver cannot stall; reset clears the controller and output strobe
// depends on sdai_pkg, sdai_ctrl, sdai_dp

module signed_int_to_decimal_ascii_unit
  import sdai_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueWidth-1:0] value_i,
  output logic [CharWidth-1:0]  character_o,
  output logic                  last_o,
  output logic                  valid_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sdai_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_o    (cmd),
    .status_i (status)
  );

  sdai_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_i     (value_i),
    .character_o (character_o),
    .last_o      (last_o),
    .valid_o     (valid_o)
  );

endmodule

>>> hdl/sdai_ctrl.sv
// controller state machine for the signed integer to decimal text unit
// depends on sdai_pkg

module sdai_ctrl
  import sdai_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StPrep,
    StDigit
  } state_e;

  state_e                  state_q, state_d;
  logic [StepCntWidth-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.shift = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == StepCntWidth'(NumSteps - 1)) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = StDigit;
      end
      StDigit: begin
        cmd_o.emit_digit = 1'b1;
        if (status_i.ptr_zero) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

>>> hdl/sdai_dp.sv
// datapath for the signed integer to decimal text unit: magnitude, bcd
// conversion by shift-and-add-3, leading digit pointer, output registers
// depends on sdai_pkg

module sdai_dp
  import sdai_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic [ValueWidth-1:0] value_i,
  output logic [CharWidth-1:0]  character_o,
  output logic                  last_o,
  output logic                  valid_o
);

  logic [ValueWidth-1:0] mag_q, mag_d;
  logic [BcdWidth-1:0]   bcd_q, bcd_d;
  logic [PtrWidth-1:0]   ptr_q, ptr_d;
  logic                  neg_q, neg_d;
  logic [CharWidth-1:0]  char_q, char_d;
  logic                  last_q, last_d;
  logic                  valid_q, valid_d;
  logic [PtrWidth-1:0]   lead_idx;
  logic [DigitWidth-1:0] cur_digit;

  // one bit of double dabble: adjust every digit, then shift in b
  function automatic logic [BcdWidth-1:0] dabble(input logic [BcdWidth-1:0] bcd,
                                                 input logic b);
    logic [BcdWidth-1:0]   adj;
    logic [DigitWidth-1:0] nib;
    for (int d = 0; d < NumDigits; d++) begin
      nib = bcd[d*DigitWidth +: DigitWidth];
      if (nib >= 4'd5) begin
        nib = nib + 4'd3;
      end
      adj[d*DigitWidth +: DigitWidth] = nib;
    end
    return {adj[BcdWidth-2:0], b};
  endfunction

  // highest nonzero digit, zero when all digits are zero
  always_comb begin
    lead_idx = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd_q[d*DigitWidth +: DigitWidth] != '0) begin
        lead_idx = PtrWidth'(d);
      end
    end
  end

  assign cur_digit = bcd_q[ptr_q*DigitWidth +: DigitWidth];

  always_comb begin
    logic [BcdWidth-1:0] acc;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    ptr_d   = ptr_q;
    neg_d   = neg_q;
    char_d  = char_q;
    last_d  = last_q;
    valid_d = 1'b0;
    acc     = bcd_q;
    if (cmd_i.load) begin
      neg_d = value_i[ValueWidth-1];
      mag_d = value_i[ValueWidth-1] ? (ValueWidth'(0) - value_i) : value_i;
      bcd_d = '0;
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < BitsPerStep; i++) begin
        acc = dabble(acc, mag_q[ValueWidth-1-i]);
      end
      bcd_d = acc;
      mag_d = mag_q << BitsPerStep;
    end
    if (cmd_i.prep) begin
      ptr_d = lead_idx;
      if (neg_q) begin
        char_d  = CharMinus;
        last_d  = 1'b0;
        valid_d = 1'b1;
      end
    end
    if (cmd_i.emit_digit) begin
      char_d  = CharWidth'(CharZero + {2'b00, cur_digit});
      last_d  = (ptr_q == '0);
      valid_d = 1'b1;
      if (ptr_q != '0) begin
        ptr_d = ptr_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    ptr_q  <= ptr_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign status_o.ptr_zero = (ptr_q == '0);
  assign character_o       = char_q;
  assign last_o            = last_q;
  assign valid_o           = valid_q;

endmodule
